// File: rtl/tws_pkg.sv
package tws_pkg;

   localparam int COUNT_BITS = 24;
   localparam int GOAL_BITS  = 24;
   localparam int DIFF_W     = (COUNT_BITS > GOAL_BITS ? COUNT_BITS : GOAL_BITS) + 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_INTERVAL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_EXTRA   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_TOL      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STALL_MIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER_STEP    = 3'd4;

   localparam logic [15:0] SYNC_INTERVAL_RST = 16'd100;
   localparam logic [15:0] FIRST_EXTRA_RST   = 16'd200;
   localparam logic [23:0] SYNC_TOL_RST      = 24'd20;
   localparam logic [15:0] STALL_MIN_RST     = 16'd10;
   localparam logic [3:0]  POWER_STEP_RST    = 4'd2;

   localparam logic signed [7:0] POWER_MAX = 8'sd100;
   localparam logic signed [7:0] POWER_MIN = -8'sd100;

   typedef enum logic {
      OP_START  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef struct packed {
      op_type                        opcode;
      logic signed [7:0]             speed;
      logic [GOAL_BITS-1:0]          target_ticks;
      logic signed [COUNT_BITS-1:0]  left_count;
      logic signed [COUNT_BITS-1:0]  right_count;
      logic [31:0]                   time_ms;
   } req_type;

   typedef struct packed {
      logic signed [7:0] left_drive;
      logic signed [7:0] right_drive;
      logic              done_res;
      logic              stalled;
   } rsp_type;

   typedef struct packed {
      logic [15:0] sync_interval_ms;
      logic [15:0] first_sync_extra_ms;
      logic [23:0] sync_tolerance;
      logic [15:0] stall_min_ticks;
      logic [3:0]  power_step;
   } cfg_type;

   function automatic logic signed [7:0] sat100(input logic signed [8:0] v);
      logic signed [7:0] r;
      if (v > 9'sd100) begin
         r = POWER_MAX;
      end else if (v < -9'sd100) begin
         r = POWER_MIN;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   function automatic logic [COUNT_BITS-1:0] count_mag(input logic signed [COUNT_BITS-1:0] c);
      logic [COUNT_BITS-1:0] r;
      if (c[COUNT_BITS-1]) begin
         r = COUNT_BITS'(-c);
      end else begin
         r = COUNT_BITS'(c);
      end
      return r;
   endfunction

   function automatic logic [DIFF_W-1:0] abs_diff(input logic [DIFF_W-1:0] a,
                                                  input logic [DIFF_W-1:0] b);
      logic [DIFF_W-1:0] r;
      if (a >= b) begin
         r = a - b;
      end else begin
         r = b - a;
      end
      return r;
   endfunction

endpackage

// File: rtl/tws_cfg.sv
module tws_cfg (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tws_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tws_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output tws_pkg::cfg_type                 cfg
);

   tws_pkg::cfg_type cfg_ff;
   tws_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            tws_pkg::CSR_SYNC_INTERVAL: cfg_in.sync_interval_ms    = csr_wdata[15:0];
            tws_pkg::CSR_FIRST_EXTRA:   cfg_in.first_sync_extra_ms = csr_wdata[15:0];
            tws_pkg::CSR_SYNC_TOL:      cfg_in.sync_tolerance      = csr_wdata[23:0];
            tws_pkg::CSR_STALL_MIN:     cfg_in.stall_min_ticks     = csr_wdata[15:0];
            tws_pkg::CSR_POWER_STEP:    cfg_in.power_step          = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_interval_ms    <= tws_pkg::SYNC_INTERVAL_RST;
         cfg_ff.first_sync_extra_ms <= tws_pkg::FIRST_EXTRA_RST;
         cfg_ff.sync_tolerance      <= tws_pkg::SYNC_TOL_RST;
         cfg_ff.stall_min_ticks     <= tws_pkg::STALL_MIN_RST;
         cfg_ff.power_step          <= tws_pkg::POWER_STEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/tws_core.sv
module tws_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  tws_pkg::req_type  req,
   input  tws_pkg::cfg_type  cfg,
   output tws_pkg::rsp_type  rsp
);

   localparam int CB = tws_pkg::COUNT_BITS;
   localparam int DW = tws_pkg::DIFF_W;

   logic                   running_ff, running_in;
   logic                   stall_ff, stall_in;
   logic signed [7:0]      base_ff, base_in;
   logic [23:0]            goal_ff, goal_in;
   logic signed [7:0]      lpow_ff, lpow_in;
   logic signed [7:0]      rpow_ff, rpow_in;
   logic signed [7:0]      lout_ff, lout_in;
   logic signed [7:0]      rout_ff, rout_in;
   logic [CB-1:0]          prev_l_ff, prev_l_in;
   logic [CB-1:0]          prev_r_ff, prev_r_in;
   logic [31:0]            next_ff, next_in;

   logic [CB-1:0]          cl, cr;
   logic [DW-1:0]          cl_x, cr_x, goal_x, dl, dr, df;
   logic                   l_reached, r_reached, check, stop;
   logic signed [8:0]      step_x, lpow_x, rpow_x, speed_x;

   always_comb begin
      cl      = tws_pkg::count_mag(req.left_count);
      cr      = tws_pkg::count_mag(req.right_count);
      cl_x    = DW'(cl);
      cr_x    = DW'(cr);
      goal_x  = DW'(goal_ff);
      dl      = tws_pkg::abs_diff(cl_x, DW'(prev_l_ff));
      dr      = tws_pkg::abs_diff(cr_x, DW'(prev_r_ff));
      df      = tws_pkg::abs_diff(cl_x, cr_x);
      l_reached = cl_x >= goal_x;
      r_reached = cr_x >= goal_x;
      check   = req.time_ms >= next_ff;
      step_x  = signed'({5'd0, cfg.power_step});
      lpow_x  = {lpow_ff[7], lpow_ff};
      rpow_x  = {rpow_ff[7], rpow_ff};
      speed_x = {req.speed[7], req.speed};
      stop    = check &&
                ((dl < DW'(cfg.stall_min_ticks) && lout_ff != 8'sd0) ||
                 (dr < DW'(cfg.stall_min_ticks) && rout_ff != 8'sd0));
   end

   always_comb begin
      running_in = running_ff;
      stall_in   = stall_ff;
      base_in    = base_ff;
      goal_in    = goal_ff;
      lpow_in    = lpow_ff;
      rpow_in    = rpow_ff;
      lout_in    = lout_ff;
      rout_in    = rout_ff;
      prev_l_in  = prev_l_ff;
      prev_r_in  = prev_r_ff;
      next_in    = next_ff;
      if (req.opcode == tws_pkg::OP_START) begin
         base_in    = tws_pkg::sat100(speed_x);
         goal_in    = req.target_ticks;
         lpow_in    = base_in;
         rpow_in    = base_in;
         prev_l_in  = '0;
         prev_r_in  = '0;
         next_in    = req.time_ms + 32'(cfg.sync_interval_ms) + 32'(cfg.first_sync_extra_ms);
         stall_in   = 1'b0;
         running_in = req.target_ticks != '0;
         lout_in    = running_in ? base_in : 8'sd0;
         rout_in    = running_in ? base_in : 8'sd0;
      end else if (running_ff) begin
         if (l_reached && r_reached) begin
            running_in = 1'b0;
            stall_in   = 1'b0;
            lout_in    = 8'sd0;
            rout_in    = 8'sd0;
         end else begin
            if (check) begin
               if (!stop && df > DW'(cfg.sync_tolerance)) begin
                  if (cl_x < cr_x) begin
                     if (lpow_ff < base_ff) begin
                        lpow_in = tws_pkg::sat100(lpow_x + step_x);
                        lout_in = lpow_in;
                     end else begin
                        rpow_in = tws_pkg::sat100(rpow_x - step_x);
                        rout_in = rpow_in;
                     end
                  end else begin
                     if (rpow_ff < base_ff) begin
                        rpow_in = tws_pkg::sat100(rpow_x + step_x);
                        rout_in = rpow_in;
                     end else begin
                        lpow_in = tws_pkg::sat100(lpow_x - step_x);
                        lout_in = lpow_in;
                     end
                  end
               end
               next_in   = req.time_ms + 32'(cfg.sync_interval_ms);
               prev_l_in = cl;
               prev_r_in = cr;
            end
            if (l_reached) begin
               lout_in = 8'sd0;
            end
            if (r_reached) begin
               rout_in = 8'sd0;
            end
            if (stop) begin
               running_in = 1'b0;
               stall_in   = 1'b1;
               lout_in    = 8'sd0;
               rout_in    = 8'sd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         stall_ff   <= 1'b0;
         base_ff    <= '0;
         goal_ff    <= '0;
         lpow_ff    <= '0;
         rpow_ff    <= '0;
         lout_ff    <= '0;
         rout_ff    <= '0;
         prev_l_ff  <= '0;
         prev_r_ff  <= '0;
         next_ff    <= '0;
      end else if (step_en) begin
         running_ff <= running_in;
         stall_ff   <= stall_in;
         base_ff    <= base_in;
         goal_ff    <= goal_in;
         lpow_ff    <= lpow_in;
         rpow_ff    <= rpow_in;
         lout_ff    <= lout_in;
         rout_ff    <= rout_in;
         prev_l_ff  <= prev_l_in;
         prev_r_ff  <= prev_r_in;
         next_ff    <= next_in;
      end
   end

   always_comb begin
      rsp.left_drive  = lout_in;
      rsp.right_drive = rout_in;
      rsp.done_res    = !running_in;
      rsp.stalled     = stall_in;
   end

endmodule

// File: rtl/two_wheel_encoder_sync_drive.sv
// channel    direction  ports                           transaction
// req        in         req_valid req_stall req_data    start or encoder sample
// rsp        out        rsp_valid rsp_stall rsp_data    drive powers and status
// csr        in         csr_we csr_index csr_wdata      register write
//
// one transaction per cycle sustained while rsp_stall is low; rsp_data is driven from the result register
// each req transaction passes input register, one update of the drive state, result register
// reset is synchronous and clears the pipeline, drive state and registers to defaults
// req_stall rises only while the input register is full and the result register is stalled
module two_wheel_encoder_sync_drive (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  tws_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output tws_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [tws_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tws_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic              in_valid_ff, in_valid_in;
   tws_pkg::req_type  in_data_ff;
   logic              out_valid_ff, out_valid_in;
   tws_pkg::rsp_type  out_data_ff;
   logic              advance, step_en, req_take;
   tws_pkg::cfg_type  cfg;
   tws_pkg::rsp_type  core_rsp;

   tws_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tws_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (core_rsp)
   );

   always_comb begin
      advance      = !out_valid_ff || !rsp_stall;
      step_en      = in_valid_ff && advance;
      req_stall    = in_valid_ff && !advance;
      req_take     = req_valid && !req_stall;
      in_valid_in  = (in_valid_ff && !advance) || req_valid;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (step_en) begin
         out_data_ff <= core_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTHESIS
   a_stall_implies_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stalled |-> rsp_data.done_res)
      else $error("stalled result without done");

   a_idle_drives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |->
         rsp_data.left_drive == 8'sd0 && rsp_data.right_drive == 8'sd0)
      else $error("drive nonzero after move ended");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.left_drive >= tws_pkg::POWER_MIN &&
         rsp_data.left_drive <= tws_pkg::POWER_MAX &&
         rsp_data.right_drive >= tws_pkg::POWER_MIN &&
         rsp_data.right_drive <= tws_pkg::POWER_MAX)
      else $error("drive power out of range");

   a_step_lands: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_valid && !in_valid_ff == !$past(req_take))
      else $error("transaction lost between stages");
`endif

endmodule
